/* hdl/stq_pkg.sv */
package stq_pkg;

  // Default number of queue slots.
  localparam int unsigned SLOTS_DEF = 16;

  // One tick hands out at most this many expiries.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned KW = $clog2(MAX_RESULTS + 1);

  localparam logic [63:0] DEADLINE_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_NONE      = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DN_RD,
    ST_DN_WR,
    ST_UP_RD,
    ST_UP_WR,
    ST_INS_WR
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] tag;
    logic [30:0] interval;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] tag_out;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] tag;
  } entry_t;

endpackage

/* hdl/sorted_timeout_queue.sv */
// Sorted timeout queue: a table of SLOTS timeouts held in deadline order.
// A command is transferred at a rising edge with start_i high and busy_o
// low; in_i carries op, tag and interval. A tick advances the 64-bit tick
// counter and reports, in queue order, the tag of each entry whose deadline
// has been reached (at most 16 per tick), or one "nothing expired" result.
// An add queues tag at deadline counter plus interval (saturating) behind
// all equal or earlier deadlines, or reports the table full. A cancel
// removes the first entry carrying tag, or reports it not found. Op 3 is
// taken and ignored.
// Each result is shown on res_o for exactly one cycle with res_valid_o high;
// res_o.last marks the final result of a command. The receiver cannot stall,
// so results never back up. Entries live in a single-port-write, registered-
// read RAM; each scan step is a read state then a compare state, and each
// entry move a read state then a write state. busy_o is high throughout a
// command; a full-table add and op 3 leave it low and their result, if any,
// shows in the cycle after the command is taken.
// Reset clears the tick counter and empties the queue at once; no RAM
// clearing pass is needed because the fill count guards every read.
module sorted_timeout_queue
  import stq_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  in_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [KW-1:0]   k_q, k_d;
  logic            pend_q, pend_d;
  logic [15:0]     pend_tag_q, pend_tag_d;
  logic [63:0]     tick_q, tick_d;
  logic [1:0]      op_q, op_d;
  logic [15:0]     tag_q, tag_d;
  logic [63:0]     dl_q, dl_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;

  logic [64:0]     dl_sum;
  logic [CW-1:0]   idx_dec;
  logic            accept;

  stq_ram #(
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign dl_sum  = {1'b0, tick_q} + 65'(in_i.interval);
  assign idx_dec = idx_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_tag_d  = pend_tag_q;
    tick_d      = tick_q;
    op_d        = op_q;
    tag_d       = tag_q;
    dl_d        = dl_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_raddr   = idx_q[AW-1:0];
    ram_wdata   = ram_rdata;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = in_i.op;
          tag_d = in_i.tag;
          dl_d  = dl_sum[64] ? DEADLINE_MAX : dl_sum[63:0];
          idx_d = '0;
          case (in_i.op)
            OP_TICK: begin
              tick_d  = tick_q + 64'd1;
              k_d     = '0;
              pend_d  = 1'b0;
              state_d = ST_TICK_RD;
            end
            OP_ADD: begin
              if (cnt_q == CW'(SLOTS)) begin
                res_valid_d = 1'b1;
                res_d       = '{kind: KIND_FULL, tag_out: in_i.tag, last: 1'b1};
              end else begin
                state_d = ST_SCAN_RD;
              end
            end
            OP_CANCEL: begin
              state_d = ST_SCAN_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Look at the head of the queue unless the queue is empty or this tick
      // has already used up its expiry budget.
      ST_TICK_RD: begin
        if (cnt_q == '0 || k_q == KW'(MAX_RESULTS)) begin
          res_valid_d = 1'b1;
          res_d = pend_q ? '{kind: KIND_EXPIRED, tag_out: pend_tag_q, last: 1'b1}
                         : '{kind: KIND_NONE, tag_out: 16'd0, last: 1'b1};
          state_d = ST_IDLE;
        end else begin
          ram_raddr = '0;
          state_d   = ST_TICK_CMP;
        end
      end

      // An expiry is held back one step so that its last flag is known
      // before it is shown.
      ST_TICK_CMP: begin
        if (ram_rdata.deadline <= tick_q) begin
          if (pend_q) begin
            res_valid_d = 1'b1;
            res_d = '{kind: KIND_EXPIRED, tag_out: pend_tag_q, last: 1'b0};
          end
          pend_d     = 1'b1;
          pend_tag_d = ram_rdata.tag;
          k_d        = k_q + KW'(1);
          idx_d      = CW'(1);
          state_d    = ST_DN_RD;
        end else begin
          res_valid_d = 1'b1;
          res_d = pend_q ? '{kind: KIND_EXPIRED, tag_out: pend_tag_q, last: 1'b1}
                         : '{kind: KIND_NONE, tag_out: 16'd0, last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        if (idx_q >= cnt_q) begin
          if (op_q == OP_ADD) begin
            pos_d   = cnt_q;
            idx_d   = cnt_q;
            state_d = ST_UP_RD;
          end else begin
            res_valid_d = 1'b1;
            res_d   = '{kind: KIND_NOT_FOUND, tag_out: tag_q, last: 1'b1};
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (op_q == OP_ADD) begin
          if (ram_rdata.deadline > dl_q) begin
            pos_d   = idx_q;
            idx_d   = cnt_q;
            state_d = ST_UP_RD;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_SCAN_RD;
          end
        end else begin
          if (ram_rdata.tag == tag_q) begin
            res_valid_d = 1'b1;
            res_d   = '{kind: KIND_CANCELLED, tag_out: tag_q, last: 1'b1};
            idx_d   = idx_q + CW'(1);
            state_d = ST_DN_RD;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_SCAN_RD;
          end
        end
      end

      // Close a gap: move entries idx..cnt-1 one slot toward the head.
      ST_DN_RD: begin
        if (idx_q >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = (op_q == OP_TICK) ? ST_TICK_RD : ST_IDLE;
        end else begin
          state_d = ST_DN_WR;
        end
      end

      ST_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_dec[AW-1:0];
        idx_d     = idx_q + CW'(1);
        state_d   = ST_DN_RD;
      end

      // Open a gap at pos: move entries from the tail one slot back.
      ST_UP_RD: begin
        if (idx_q == pos_q) begin
          state_d = ST_INS_WR;
        end else begin
          ram_raddr = idx_dec[AW-1:0];
          state_d   = ST_UP_WR;
        end
      end

      ST_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        idx_d     = idx_dec;
        state_d   = ST_UP_RD;
      end

      ST_INS_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_q[AW-1:0];
        ram_wdata   = '{deadline: dl_q, tag: tag_q};
        cnt_d       = cnt_q + CW'(1);
        res_valid_d = 1'b1;
        res_d       = '{kind: KIND_ADDED, tag_out: tag_q, last: 1'b1};
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      tick_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      tick_q      <= tick_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    pend_tag_q <= pend_tag_d;
    op_q       <= op_d;
    tag_q      <= tag_d;
    dl_q       <= dl_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The fill count never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(SLOTS))
    else $error("queue fill count exceeds the table size");

  // A tick never takes more expiries than its budget.
  assert property (@(posedge clk_i) disable iff (!rst_ni) k_q <= KW'(MAX_RESULTS))
    else $error("expiry budget overrun");

  // The RAM is only written while a command is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> busy_o)
    else $error("RAM write while idle");

  // A scan compares only queued entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CMP) |-> (idx_q < cnt_q))
    else $error("scan read beyond the queued entries");

  // A result follows either a command in progress or a command just taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o || start_i))
    else $error("result without a command");

endmodule

/* hdl/stq_ram.sv */
module stq_ram
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
